/* hdl/ftd_pkg.sv */
// Package: widths, constants and cell transfer type for the truncating divider.
package ftd_pkg;
    localparam int unsigned MantW  = 24;
    localparam int unsigned QuotW  = 25;
    localparam int unsigned NCells = QuotW;
    localparam logic [7:0] ExpBiasLo = 8'd126;
    localparam logic [7:0] TopByteBit = 8'h80;

    typedef struct packed {
        logic              valid;
        logic [MantW:0]    rem;
        logic [MantW-1:0]  div;
        logic [QuotW-1:0]  quo;
        logic              sgn;
        logic [7:0]        exp;
    } t_cell;
endpackage

/* hdl/ftd_cell.sv */
// One restoring-division cell: forms one quotient bit and passes the partial result on.
module ftd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  ftd_pkg::t_cell i_d,
    output ftd_pkg::t_cell o_q
);
    ftd_pkg::t_cell r_q;
    ftd_pkg::t_cell n_q;
    logic [ftd_pkg::MantW+1:0] w_diff;

    always_comb begin
        n_q    = i_d;
        w_diff = {1'b0, i_d.rem} - {2'b00, i_d.div};
        // take the difference when non-negative, then shift for the next bit
        if (!w_diff[ftd_pkg::MantW+1]) begin
            n_q.rem = {w_diff[ftd_pkg::MantW-1:0], 1'b0};
            n_q.quo = {i_d.quo[ftd_pkg::QuotW-2:0], 1'b1};
        end else begin
            n_q.rem = {i_d.rem[ftd_pkg::MantW-1:0], 1'b0};
            n_q.quo = {i_d.quo[ftd_pkg::QuotW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= i_d.valid;
        end
        if (i_en) begin
            r_q.rem <= n_q.rem;
            r_q.div <= n_q.div;
            r_q.quo <= n_q.quo;
            r_q.sgn <= n_q.sgn;
            r_q.exp <= n_q.exp;
        end
    end

    assign o_q = r_q;
endmodule

/* hdl/float32_truncating_divider_top.sv */
// Top level: pipelined float32 truncating divider built from a chain of division cells.
//
//  channel | signals                               | direction
//  input   | i_valid, o_ready, i_dividend_bits,    | in
//          | i_divisor_bits                        |
//  output  | o_valid, i_ready, o_quotient_bits     | out
//
// One transaction per cycle while the output is not stalled; each item passes one register
// per quotient bit cell (25) and then the output register. The whole chain advances only
// while the output register is empty or being taken, so a stall on the output holds every
// stage. Reset clears all valid bits; payload registers are not reset.
module float32_truncating_divider_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_dividend_bits,
    input  logic [31:0] i_divisor_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_quotient_bits
);
    localparam int unsigned N = ftd_pkg::NCells;

    ftd_pkg::t_cell w_chain [N+1];
    logic           w_en;
    logic           r_valid;
    logic [31:0]    r_quot;
    logic [ftd_pkg::QuotW-1:0] w_q;
    logic [7:0]     w_e;

    // advance when the output slot is free or is being taken this cycle
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_chain[0].valid = i_valid;
        // first compare is of mx against my, the remainder starts as mx
        w_chain[0].rem   = {1'b0, ftd_pkg::TopByteBit, 16'h0000} |
                           {2'b00, i_dividend_bits[22:0]};
        w_chain[0].div   = {1'b1, i_divisor_bits[22:0]};
        w_chain[0].quo   = '0;
        w_chain[0].sgn   = i_dividend_bits[31] ^ i_divisor_bits[31];
        w_chain[0].exp   = ftd_pkg::ExpBiasLo + i_dividend_bits[30:23] - i_divisor_bits[30:23];
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        ftd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_d    (w_chain[g]),
            .o_q    (w_chain[g+1])
        );
    end

    assign w_q = w_chain[N].quo;
    assign w_e = w_chain[N].exp + {7'd0, w_q[ftd_pkg::QuotW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_chain[N].valid;
        end
        if (w_en) begin
            r_quot <= {w_chain[N].sgn, w_e,
                       w_q[ftd_pkg::QuotW-1] ? w_q[23:1] : w_q[22:0]};
        end
    end

    assign o_valid         = r_valid;
    assign o_quotient_bits = r_quot;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quotient_bits))
        else $error("result changed under stall");
    // ready follows the output slot
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready mismatch");
    // last cell quotient is normalised to [2^23, 2^25)
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[N].valid |-> (w_q[24] || w_q[23]))
        else $error("quotient not normalised");
endmodule
